// ===== rtl/core/trail_point_store_decimating_assert.svh =====
// Assertion macros shared by the trail point store RTL.
`ifndef TRAIL_POINT_STORE_DECIMATING_ASSERT_SVH
`define TRAIL_POINT_STORE_DECIMATING_ASSERT_SVH
`ifndef SYNTHESIS
`define TPS_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define TPS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define TPS_ASSERT_IMP(label, clk, rst_n, pre, post)
`define TPS_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/core/tps_pkg.sv =====
// Package with the types and constants of the trail point store.
`timescale 1ns / 1ps
`default_nettype none
package tps_pkg;
    localparam int CAPACITY = 256;
    localparam int COORD_BITS = 24;
    localparam int ADDR_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS = ADDR_BITS + 1;
    localparam int STEP_BITS = 49;
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int SQ_BITS = 2 * DIFF_BITS;
    localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(256);
    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_READ = 2'd1;
    localparam logic [1:0] FUNC_BOUNDS = 2'd2;
    localparam logic [1:0] FUNC_CLEAR = 2'd3;

    typedef struct packed {
        logic load;
        logic calc;
        logic append;
        logic clear;
        logic rd_req;
        logic bnd_init;
        logic bnd_acc;
        logic dec_copy;
        logic dec_finish;
        logic out_load;
        logic out_take;
    } tps_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic empty;
        logic full;
        logic far;
        logic idx_ok;
        logic scan_last;
        logic dec_last;
        logic out_busy;
    } tps_stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/tps_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/tps_datapath.sv =====
// Datapath of the trail point store: memories, pointers, distance and bounds.
`timescale 1ns / 1ps
`default_nettype none
`include "trail_point_store_decimating_assert.svh"
module tps_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire tps_pkg::tps_cmd_t                cmd,
    output tps_pkg::tps_stat_t                    stat,
    input  wire logic                             cfg_we,
    input  wire logic [tps_pkg::STEP_BITS-1:0]    cfg_data,
    input  wire logic [1:0]                       func,
    input  wire logic [tps_pkg::COORD_BITS-1:0]   pos_x,
    input  wire logic [tps_pkg::COORD_BITS-1:0]   pos_y,
    input  wire logic [7:0]                       index,
    output logic                                  out_valid,
    output logic                                  accepted,
    output logic                                  decimated,
    output logic [tps_pkg::CNT_BITS-1:0]          stored_count,
    output logic [tps_pkg::COORD_BITS-1:0]        point_x,
    output logic [tps_pkg::COORD_BITS-1:0]        point_y,
    output logic [tps_pkg::COORD_BITS-1:0]        min_x,
    output logic [tps_pkg::COORD_BITS-1:0]        max_x,
    output logic [tps_pkg::COORD_BITS-1:0]        min_y,
    output logic [tps_pkg::COORD_BITS-1:0]        max_y
);
    import tps_pkg::*;

    logic [STEP_BITS-1:0] step_reg;
    logic [ADDR_BITS-1:0] wpos_reg;
    logic [CNT_BITS-1:0] fill_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic [1:0] func_reg;
    logic signed [COORD_BITS-1:0] in_x_reg, in_y_reg;
    logic [7:0] index_reg;
    logic signed [SQ_BITS-1:0] sqx_reg, sqy_reg;
    logic dec_flag_reg;

    // Scan engine: read pointer, logical counters, pipelined valid.
    logic [CNT_BITS-1:0] scan_cnt_reg;
    logic [CNT_BITS-1:0] scan_wr_reg;
    logic [ADDR_BITS-1:0] rd_addr;
    logic rd_vld_reg;
    logic signed [COORD_BITS-1:0] rdx, rdy;
    logic signed [COORD_BITS-1:0] bmnx_reg, bmxx_reg, bmny_reg, bmxy_reg;
    logic bfirst_reg;

    logic [ADDR_BITS-1:0] base;
    logic [CNT_BITS-1:0] half;
    logic [CNT_BITS-1:0] logical;
    logic ram_we;
    logic [ADDR_BITS-1:0] ram_waddr;
    logic [COORD_BITS-1:0] ram_wx, ram_wy;

    assign base = wpos_reg - fill_reg[ADDR_BITS-1:0];
    assign half = fill_reg >> 1;

    // Logical index of the next entry to fetch.
    always_comb
    begin
        if (cmd.rd_req)
        begin
            logical = CNT_BITS'(index_reg);
        end
        else if (cmd.dec_copy && (scan_cnt_reg < ((half + 1'b1) >> 1)))
        begin
            logical = scan_cnt_reg << 1;
        end
        else if (cmd.dec_copy)
        begin
            logical = scan_cnt_reg + (half - ((half + 1'b1) >> 1));
        end
        else
        begin
            logical = scan_cnt_reg;
        end
    end
    assign rd_addr = base + logical[ADDR_BITS-1:0];

    // Decimation copies the kept entries in place, to consecutive addresses from zero.
    assign ram_we = cmd.append || (cmd.dec_copy && rd_vld_reg);
    assign ram_waddr = cmd.append ? wpos_reg : scan_wr_reg[ADDR_BITS-1:0];
    assign ram_wx = cmd.append ? in_x_reg : rdx;
    assign ram_wy = cmd.append ? in_y_reg : rdy;

    tps_ram #(.WIDTH(COORD_BITS), .DEPTH(CAPACITY)) u_ram_x (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wx),
        .raddr(rd_addr), .rdata(rdx)
    );
    tps_ram #(.WIDTH(COORD_BITS), .DEPTH(CAPACITY)) u_ram_y (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wy),
        .raddr(rd_addr), .rdata(rdy)
    );

    logic signed [DIFF_BITS-1:0] dx, dy;
    logic [SQ_BITS:0] dist_sum;
    logic [CNT_BITS-1:0] keep_cnt;
    assign dx = DIFF_BITS'(in_x_reg) - DIFF_BITS'(prev_x_reg);
    assign dy = DIFF_BITS'(in_y_reg) - DIFF_BITS'(prev_y_reg);
    assign dist_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign keep_cnt = ((half + 1'b1) >> 1) + (fill_reg - half);

    assign stat.func = func_reg;
    assign stat.empty = (fill_reg == '0);
    assign stat.full = (fill_reg == CNT_BITS'(CAPACITY));
    assign stat.far = (SQ_BITS + 1 > STEP_BITS) ? (dist_sum >= (SQ_BITS+1)'(step_reg))
                                                 : (STEP_BITS'(dist_sum) >= step_reg);
    assign stat.idx_ok = (CNT_BITS'(index_reg) < fill_reg);
    assign stat.scan_last = (scan_cnt_reg + 1'b1 >= fill_reg);
    assign stat.dec_last = (scan_cnt_reg + 1'b1 >= keep_cnt);
    assign stat.out_busy = out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
            wpos_reg <= '0;
            fill_reg <= '0;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            out_valid <= 1'b0;
            rd_vld_reg <= 1'b0;
            scan_cnt_reg <= '0;
            scan_wr_reg <= '0;
            dec_flag_reg <= 1'b0;
            bfirst_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                step_reg <= cfg_data;
            end
            rd_vld_reg <= cmd.rd_req || cmd.bnd_acc || cmd.dec_copy;
            if (cmd.load)
            begin
                dec_flag_reg <= 1'b0;
                scan_cnt_reg <= '0;
                scan_wr_reg <= '0;
                bfirst_reg <= 1'b1;
            end
            if (cmd.bnd_acc || cmd.dec_copy)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            if (rd_vld_reg && (cmd.bnd_acc || cmd.bnd_init))
            begin
                bfirst_reg <= 1'b0;
            end
            if (cmd.dec_copy && rd_vld_reg)
            begin
                scan_wr_reg <= scan_wr_reg + 1'b1;
            end
            if (cmd.dec_finish)
            begin
                fill_reg <= scan_wr_reg;
                wpos_reg <= scan_wr_reg[ADDR_BITS-1:0];
                dec_flag_reg <= 1'b1;
            end
            if (cmd.append)
            begin
                wpos_reg <= wpos_reg + 1'b1;
                if (fill_reg != CNT_BITS'(CAPACITY))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                prev_x_reg <= in_x_reg;
                prev_y_reg <= in_y_reg;
            end
            if (cmd.clear)
            begin
                wpos_reg <= '0;
                fill_reg <= '0;
                prev_x_reg <= '0;
                prev_y_reg <= '0;
            end
            if (cmd.out_load)
            begin
                out_valid <= 1'b1;
            end
            else if (cmd.out_take)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    logic [CNT_BITS-1:0] fill_after;
    assign fill_after = cmd.append ? ((fill_reg == CNT_BITS'(CAPACITY)) ? fill_reg
                                                                           : fill_reg + 1'b1)
                                   : (cmd.clear ? '0 : fill_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            in_x_reg <= pos_x;
            in_y_reg <= pos_y;
            index_reg <= index;
        end
        if (cmd.calc)
        begin
            sqx_reg <= dx * dx;
            sqy_reg <= dy * dy;
        end
        if (cmd.bnd_init)
        begin
            bmnx_reg <= '0;
            bmxx_reg <= '0;
            bmny_reg <= '0;
            bmxy_reg <= '0;
        end
        if (rd_vld_reg && (cmd.bnd_acc || cmd.bnd_init))
        begin
            if (bfirst_reg || rdx < bmnx_reg) bmnx_reg <= rdx;
            if (bfirst_reg || rdx > bmxx_reg) bmxx_reg <= rdx;
            if (bfirst_reg || rdy < bmny_reg) bmny_reg <= rdy;
            if (bfirst_reg || rdy > bmxy_reg) bmxy_reg <= rdy;
        end
        if (cmd.out_load)
        begin
            accepted <= cmd.append;
            decimated <= cmd.append && dec_flag_reg;
            stored_count <= fill_after;
            point_x <= (func_reg == FUNC_READ && stat.idx_ok) ? rdx : '0;
            point_y <= (func_reg == FUNC_READ && stat.idx_ok) ? rdy : '0;
            min_x <= (func_reg == FUNC_BOUNDS) ? bmnx_reg : '0;
            max_x <= (func_reg == FUNC_BOUNDS) ? bmxx_reg : '0;
            min_y <= (func_reg == FUNC_BOUNDS) ? bmny_reg : '0;
            max_y <= (func_reg == FUNC_BOUNDS) ? bmxy_reg : '0;
        end
    end

    `TPS_ASSERT_IMP(a_fill_cap, clk, rst_n, 1'b1, fill_reg <= CNT_BITS'(CAPACITY))
    `TPS_ASSERT_IMP(a_one_write, clk, rst_n, cmd.append, !cmd.dec_copy)
    `TPS_ASSERT_NEXT(a_dec_shrinks, clk, rst_n, cmd.dec_finish,
                     fill_reg < CNT_BITS'(CAPACITY))
endmodule
`default_nettype wire

// ===== rtl/core/tps_ctrl.sv =====
// Controller state machine of the trail point store.
`timescale 1ns / 1ps
`default_nettype none
`include "trail_point_store_decimating_assert.svh"
module tps_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               out_ready,
    input  wire tps_pkg::tps_stat_t stat,
    output tps_pkg::tps_cmd_t       cmd
);
    import tps_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC = 3'd1;
    localparam logic [2:0] S_CALC = 3'd2;
    localparam logic [2:0] S_ADD = 3'd3;
    localparam logic [2:0] S_RD = 3'd4;
    localparam logic [2:0] S_BND = 3'd5;
    localparam logic [2:0] S_DRAIN = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] state_reg, state_next;
    logic drain_dec_reg, drain_dec_next;

    assign in_ready = (state_reg == S_IDLE) && !stat.out_busy;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        drain_dec_next = drain_dec_reg;
        cmd.out_take = out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load = 1'b1;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                unique case (stat.func)
                    FUNC_ADD:
                    begin
                        cmd.calc = 1'b1;
                        state_next = S_ADD;
                    end
                    FUNC_READ:
                    begin
                        cmd.rd_req = 1'b1;
                        state_next = S_RD;
                    end
                    FUNC_BOUNDS:
                    begin
                        if (stat.empty)
                        begin
                            cmd.bnd_init = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.bnd_acc = 1'b1;
                            state_next = stat.scan_last ? S_DRAIN : S_BND;
                            drain_dec_next = 1'b0;
                            cmd.bnd_init = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.clear = 1'b1;
                        cmd.out_load = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_ADD:
            begin
                if (!stat.empty && !stat.far)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.full)
                begin
                    cmd.dec_copy = 1'b1;
                    drain_dec_next = 1'b1;
                    state_next = stat.dec_last ? S_DRAIN : S_DEC;
                end
                else
                begin
                    cmd.append = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DEC:
            begin
                cmd.dec_copy = 1'b1;
                if (stat.dec_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_BND:
            begin
                cmd.bnd_acc = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (drain_dec_reg)
                begin
                    cmd.dec_copy = 1'b1;
                    cmd.dec_finish = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.bnd_acc = 1'b1;
                    state_next = S_DONE;
                end
            end
            default:
            begin
                if (drain_dec_reg)
                begin
                    cmd.dec_finish = 1'b1;
                    drain_dec_next = 1'b0;
                    state_next = S_ADD;
                end
                else
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            drain_dec_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            drain_dec_reg <= drain_dec_next;
        end
    end

    `TPS_ASSERT_IMP(a_load_idle, clk, rst_n, cmd.load, state_reg == S_IDLE)
    `TPS_ASSERT_IMP(a_out_once, clk, rst_n, cmd.out_load, !stat.out_busy)
    `TPS_ASSERT_NEXT(a_calc_follows, clk, rst_n, cmd.load, state_reg == S_CALC)
endmodule
`default_nettype wire

// ===== rtl/core/trail_point_store_decimating.sv =====
// Top level of the trail point store with distance gating and decimation.
`timescale 1ns / 1ps
`default_nettype none
// Stores up to 256 trail points in two 256-entry RAMs with registered reads.
// A bounds query and an add into a full store take longer than the other
// operations, both set by the one RAM read port walking the stored points.
// A new beat is taken once the previous result beat has been delivered.
module trail_point_store_decimating (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     func,
    input  wire logic [tps_pkg::COORD_BITS-1:0] pos_x,
    input  wire logic [tps_pkg::COORD_BITS-1:0] pos_y,
    input  wire logic [7:0]                     index,
    input  wire logic                           cfg_we,
    input  wire logic [tps_pkg::STEP_BITS-1:0]  cfg_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                accepted,
    output logic                                decimated,
    output logic [tps_pkg::CNT_BITS-1:0]        stored_count,
    output logic [tps_pkg::COORD_BITS-1:0]      point_x,
    output logic [tps_pkg::COORD_BITS-1:0]      point_y,
    output logic [tps_pkg::COORD_BITS-1:0]      min_x,
    output logic [tps_pkg::COORD_BITS-1:0]      max_x,
    output logic [tps_pkg::COORD_BITS-1:0]      min_y,
    output logic [tps_pkg::COORD_BITS-1:0]      max_y
);
    import tps_pkg::*;

    tps_cmd_t cmd;
    tps_stat_t stat;

    tps_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_ready(out_ready), .stat(stat), .cmd(cmd)
    );

    tps_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .func(func), .pos_x(pos_x), .pos_y(pos_y), .index(index),
        .out_valid(out_valid), .accepted(accepted), .decimated(decimated),
        .stored_count(stored_count), .point_x(point_x), .point_y(point_y),
        .min_x(min_x), .max_x(max_x), .min_y(min_y), .max_y(max_y)
    );
endmodule
`default_nettype wire
